// File: hw/rtl/euler_xyz_pkg.sv
package euler_xyz_pkg;

    localparam int ANGLE_WIDTH_DEF = 16;
    localparam int POS_WIDTH_DEF   = 24;

    // cordic datapath
    localparam int STEPS = 24;
    localparam int ZW    = 35;
    localparam int XW    = 34;
    localparam int CW    = 30;

    localparam logic signed [ZW-1:0] Q30_PI       = 35'sd3373259426;
    localparam logic signed [ZW-1:0] Q30_HALF_PI  = 35'sd1686629713;
    localparam logic signed [XW-1:0] Q30_INV_GAIN = 34'sd652032874;

    localparam logic signed [ZW-1:0] ATAN_TAB [0:STEPS-1] = '{
        35'sd843314856, 35'sd497837829, 35'sd263043836, 35'sd133525158,
        35'sd67021686,  35'sd33543515,  35'sd16775850,  35'sd8388437,
        35'sd4194282,   35'sd2097149,   35'sd1048575,   35'sd524287,
        35'sd262143,    35'sd131071,    35'sd65535,     35'sd32767,
        35'sd16383,     35'sd8191,      35'sd4095,      35'sd2047,
        35'sd1023,      35'sd511,       35'sd255,       35'sd127
    };

endpackage

// File: hw/rtl/euler_xyz_vector_rotation_core.sv
// channel   signals                                  direction
// in        in_valid in_ready theta_x/y/z pos_x/y/z  into core
// out       out_valid out_ready base_x/y/z           out of core
//
// one word accepted per cycle while out is not stalled
// stages: angle reduction, 24 cordic steps, sin/cos rounding,
// three multiply and add pairs (rz, ry, rx), saturation
// rst_n clears the valid bits only, payload registers are not reset
// a stall on out freezes every stage, in_ready follows the last stage
module euler_xyz_vector_rotation_core #(
    parameter int ANGLE_WIDTH = euler_xyz_pkg::ANGLE_WIDTH_DEF,
    parameter int POS_WIDTH   = euler_xyz_pkg::POS_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [ANGLE_WIDTH-1:0] theta_x,
    input  logic signed [ANGLE_WIDTH-1:0] theta_y,
    input  logic signed [ANGLE_WIDTH-1:0] theta_z,
    input  logic signed [POS_WIDTH-1:0]   pos_x,
    input  logic signed [POS_WIDTH-1:0]   pos_y,
    input  logic signed [POS_WIDTH-1:0]   pos_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [POS_WIDTH-1:0]   base_x,
    output logic signed [POS_WIDTH-1:0]   base_y,
    output logic signed [POS_WIDTH-1:0]   base_z
);
    import euler_xyz_pkg::*;

    localparam int ASH  = 33 - ANGLE_WIDTH;
    localparam int VW   = POS_WIDTH + 2;
    localparam int PW   = CW + VW;
    localparam int SW   = PW + 1;
    localparam int LAST = STEPS + 8;
    localparam logic signed [SW-1:0] RND  = SW'(64'sd134217728);
    localparam logic signed [VW-1:0] SMAX = {3'b000, {(POS_WIDTH-1){1'b1}}};
    localparam logic signed [VW-1:0] SMIN = {3'b111, {(POS_WIDTH-1){1'b0}}};

    logic [LAST:0] vld_reg;
    logic          en;

    logic signed [ANGLE_WIDTH-1:0] th [0:2];
    logic signed [ZW-1:0]          zs [0:2];
    logic signed [ZW-1:0]          z0_next [0:2];
    logic [2:0]                    flip0_next;

    logic signed [XW-1:0] cx_reg [0:STEPS][0:2];
    logic signed [XW-1:0] cy_reg [0:STEPS][0:2];
    logic signed [ZW-1:0] cz_reg [0:STEPS][0:2];
    logic [2:0]           flip_reg [0:STEPS];
    logic signed [XW-1:0] cx_next [1:STEPS][0:2];
    logic signed [XW-1:0] cy_next [1:STEPS][0:2];
    logic signed [ZW-1:0] cz_next [1:STEPS][0:2];

    logic signed [VW-1:0] vec_reg [0:STEPS+1][0:2];

    logic signed [XW-1:0] xf [0:2];
    logic signed [XW-1:0] yf [0:2];
    logic signed [XW-1:0] xr [0:2];
    logic signed [XW-1:0] yr [0:2];
    logic signed [CW-1:0] cos_reg [0:2];
    logic signed [CW-1:0] sin_reg [0:2];

    // rotation stages
    logic signed [PW-1:0] pz_reg [0:3];
    logic signed [PW-1:0] py_reg [0:3];
    logic signed [PW-1:0] px_reg [0:3];
    logic signed [VW-1:0] vz26_reg;
    logic signed [VW-1:0] vec27_reg [0:2];
    logic signed [VW-1:0] vy28_reg;
    logic signed [VW-1:0] vec29_reg [0:2];
    logic signed [VW-1:0] vx30_reg;
    logic signed [VW-1:0] vec31_reg [0:2];
    logic signed [CW-1:0] cy26_reg, sy26_reg, cy27_reg, sy27_reg;
    logic signed [CW-1:0] cx26_reg, sx26_reg, cx27_reg, sx27_reg;
    logic signed [CW-1:0] cx28_reg, sx28_reg, cx29_reg, sx29_reg;

    logic signed [SW-1:0] s27 [0:1];
    logic signed [SW-1:0] s29 [0:1];
    logic signed [SW-1:0] s31 [0:1];
    logic signed [SW-1:0] r27 [0:1];
    logic signed [SW-1:0] r29 [0:1];
    logic signed [SW-1:0] r31 [0:1];
    logic signed [VW-1:0] sat [0:2];
    logic signed [POS_WIDTH-1:0] base_reg [0:2];

    assign en        = !vld_reg[LAST] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[LAST];
    assign base_x    = base_reg[0];
    assign base_y    = base_reg[1];
    assign base_z    = base_reg[2];

    assign th[0] = theta_x;
    assign th[1] = theta_y;
    assign th[2] = theta_z;

    // angle reduction into +-pi/2
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            zs[a] = ZW'(th[a]) <<< ASH;
            if (zs[a] > Q30_HALF_PI)
            begin
                z0_next[a]    = zs[a] - Q30_PI;
                flip0_next[a] = 1'b1;
            end
            else if (zs[a] < -Q30_HALF_PI)
            begin
                z0_next[a]    = zs[a] + Q30_PI;
                flip0_next[a] = 1'b1;
            end
            else
            begin
                z0_next[a]    = zs[a];
                flip0_next[a] = 1'b0;
            end
        end
    end

    // one cordic micro-rotation per stage
    always_comb
    begin
        for (int k = 0; k < STEPS; k++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                if (cz_reg[k][a] >= 0)
                begin
                    cx_next[k+1][a] = cx_reg[k][a] - (cy_reg[k][a] >>> k);
                    cy_next[k+1][a] = cy_reg[k][a] + (cx_reg[k][a] >>> k);
                    cz_next[k+1][a] = cz_reg[k][a] - ATAN_TAB[k];
                end
                else
                begin
                    cx_next[k+1][a] = cx_reg[k][a] + (cy_reg[k][a] >>> k);
                    cy_next[k+1][a] = cy_reg[k][a] - (cx_reg[k][a] >>> k);
                    cz_next[k+1][a] = cz_reg[k][a] + ATAN_TAB[k];
                end
            end
        end
    end

    // sign fix and rounding to q.28
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            xf[a] = flip_reg[STEPS][a] ? -cx_reg[STEPS][a] : cx_reg[STEPS][a];
            yf[a] = flip_reg[STEPS][a] ? -cy_reg[STEPS][a] : cy_reg[STEPS][a];
            xr[a] = (xf[a] + XW'(2)) >>> 2;
            yr[a] = (yf[a] + XW'(2)) >>> 2;
        end
    end

    always_comb
    begin
        s27[0] = SW'(pz_reg[0]) - SW'(pz_reg[1]) + RND;
        s27[1] = SW'(pz_reg[2]) + SW'(pz_reg[3]) + RND;
        s29[0] = SW'(py_reg[0]) - SW'(py_reg[1]) + RND;
        s29[1] = SW'(py_reg[2]) + SW'(py_reg[3]) + RND;
        s31[0] = SW'(px_reg[0]) - SW'(px_reg[1]) + RND;
        s31[1] = SW'(px_reg[2]) + SW'(px_reg[3]) + RND;
        for (int i = 0; i < 2; i++)
        begin
            r27[i] = s27[i] >>> 28;
            r29[i] = s29[i] >>> 28;
            r31[i] = s31[i] >>> 28;
        end
        for (int a = 0; a < 3; a++)
        begin
            if (vec31_reg[a] > SMAX)
            begin
                sat[a] = SMAX;
            end
            else if (vec31_reg[a] < SMIN)
            begin
                sat[a] = SMIN;
            end
            else
            begin
                sat[a] = vec31_reg[a];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAST-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 3; a++)
            begin
                cx_reg[0][a] <= Q30_INV_GAIN;
                cy_reg[0][a] <= '0;
                cz_reg[0][a] <= z0_next[a];
            end
            flip_reg[0] <= flip0_next;
            vec_reg[0][0] <= VW'(pos_x);
            vec_reg[0][1] <= VW'(pos_y);
            vec_reg[0][2] <= VW'(pos_z);
            for (int k = 1; k <= STEPS; k++)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    cx_reg[k][a] <= cx_next[k][a];
                    cy_reg[k][a] <= cy_next[k][a];
                    cz_reg[k][a] <= cz_next[k][a];
                end
                flip_reg[k] <= flip_reg[k-1];
            end
            for (int k = 1; k <= STEPS + 1; k++)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    vec_reg[k][a] <= vec_reg[k-1][a];
                end
            end
            for (int a = 0; a < 3; a++)
            begin
                cos_reg[a] <= xr[a][CW-1:0];
                sin_reg[a] <= yr[a][CW-1:0];
            end

            // rz on (x, y)
            pz_reg[0] <= PW'(cos_reg[2]) * PW'(vec_reg[STEPS+1][0]);
            pz_reg[1] <= PW'(sin_reg[2]) * PW'(vec_reg[STEPS+1][1]);
            pz_reg[2] <= PW'(sin_reg[2]) * PW'(vec_reg[STEPS+1][0]);
            pz_reg[3] <= PW'(cos_reg[2]) * PW'(vec_reg[STEPS+1][1]);
            vz26_reg  <= vec_reg[STEPS+1][2];
            cy26_reg  <= cos_reg[1];
            sy26_reg  <= sin_reg[1];
            cx26_reg  <= cos_reg[0];
            sx26_reg  <= sin_reg[0];

            vec27_reg[0] <= r27[0][VW-1:0];
            vec27_reg[1] <= r27[1][VW-1:0];
            vec27_reg[2] <= vz26_reg;
            cy27_reg     <= cy26_reg;
            sy27_reg     <= sy26_reg;
            cx27_reg     <= cx26_reg;
            sx27_reg     <= sx26_reg;

            // ry on (z, x)
            py_reg[0] <= PW'(cy27_reg) * PW'(vec27_reg[2]);
            py_reg[1] <= PW'(sy27_reg) * PW'(vec27_reg[0]);
            py_reg[2] <= PW'(sy27_reg) * PW'(vec27_reg[2]);
            py_reg[3] <= PW'(cy27_reg) * PW'(vec27_reg[0]);
            vy28_reg  <= vec27_reg[1];
            cx28_reg  <= cx27_reg;
            sx28_reg  <= sx27_reg;

            vec29_reg[2] <= r29[0][VW-1:0];
            vec29_reg[0] <= r29[1][VW-1:0];
            vec29_reg[1] <= vy28_reg;
            cx29_reg     <= cx28_reg;
            sx29_reg     <= sx28_reg;

            // rx on (y, z)
            px_reg[0] <= PW'(cx29_reg) * PW'(vec29_reg[1]);
            px_reg[1] <= PW'(sx29_reg) * PW'(vec29_reg[2]);
            px_reg[2] <= PW'(sx29_reg) * PW'(vec29_reg[1]);
            px_reg[3] <= PW'(cx29_reg) * PW'(vec29_reg[2]);
            vx30_reg  <= vec29_reg[0];

            vec31_reg[1] <= r31[0][VW-1:0];
            vec31_reg[2] <= r31[1][VW-1:0];
            vec31_reg[0] <= vx30_reg;

            for (int a = 0; a < 3; a++)
            begin
                base_reg[a] <= sat[a][POS_WIDTH-1:0];
            end
        end
    end

endmodule
